// File: rtl/core/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants shared by the WebSocket frame receiver core.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_CLOSED  = 3'd0,
        PH_HDR0    = 3'd1,
        PH_HDR1    = 3'd2,
        PH_EXTLEN  = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    // Input command codes.
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Result kind codes.
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Frame opcodes that produce results.
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Header byte counts.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    // Number of payload bytes that make up the close status.
    localparam logic [1:0] SEEN_STATUS = 2'd2;

endpackage

// File: rtl/core/websocket_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver_core
// Parses received WebSocket frames byte by byte and unmasks the payload; emits
// text, ping and close payload bytes, empty frames and length errors, each with
// its kind and a last mark.
//   Channel   Dir  tdata (low bit up)                 tuser / tlast
//   s_axis    in   rx_byte[7:0]                       tuser[0] cmd
//   m_axis    out  payload_byte[7:0],                 tuser[1:0] kind,
//                  close_status[23:8]                 tuser[2] empty_frame,
//                                                     tlast last
//
// One request is taken per cycle while m_axis does not stall; its result, if
// any, appears in the output register on the next cycle. The parser state and
// the result register are the only storage, so throughput is one byte a cycle.
// The synchronous reset leaves the parser closed: data is dropped until a
// restart request. A stall on m_axis holds s_axis only while the output
// register is full and not being taken.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_core #(
    parameter int unsigned LEN_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] close_status
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] empty_frame
    output logic        m_axis_tlast    // last
);

    import wsfr_pkg::*;

    // Parser state.
    t_phase                 r_phase,      n_phase;
    logic [3:0]             r_opcode,     n_opcode;
    logic                   r_mask_on,    n_mask_on;
    logic [3:0]             r_hdr_left,   n_hdr_left;
    logic [LEN_WIDTH-1:0]   r_rem_len,    n_rem_len;
    logic                   r_len_ovf,    n_len_ovf;
    logic [31:0]            r_mask_key,   n_mask_key;
    logic [1:0]             r_mask_pos,   n_mask_pos;
    logic [1:0]             r_seen,       n_seen;
    logic [15:0]            r_close_acc,  n_close_acc;

    // Result register.
    logic                   r_out_valid;
    logic                   n_emit;
    logic [1:0]             r_kind,       n_kind;
    logic [7:0]             r_byte,       n_byte;
    logic                   r_empty,      n_empty;
    logic                   r_last,       n_last;
    logic [15:0]            r_status,     n_status;

    logic                   w_accept;
    logic                   w_data;
    logic [7:0]             w_b;
    logic [6:0]             w_len7;
    logic                   w_ext;
    logic [3:0]             w_hb_dec;
    logic                   w_ovf_ext;
    logic [LEN_WIDTH-1:0]   w_len_shift;
    logic [LEN_WIDTH-1:0]   w_len_new;
    logic                   w_mask_new;
    logic                   w_after_len;
    logic                   w_start;
    logic                   w_len_empty;
    logic                   w_ext_err;
    logic                   w_kind_ok;
    logic [1:0]             w_kind;
    logic [7:0]             w_key_byte;
    logic [7:0]             w_pay;
    logic [LEN_WIDTH-1:0]   w_rem_dec;
    logic                   w_pay_last;
    logic [1:0]             w_seen_new;
    logic [15:0]            w_close_new;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_data        = w_accept && (s_axis_tuser[0] == CMD_DATA);
    assign w_b           = s_axis_tdata;

    // Header decoding.
    assign w_len7      = w_b[6:0];
    assign w_ext       = (w_len7 == LEN7_EXT16) || (w_len7 == LEN7_EXT64);
    assign w_hb_dec    = r_hdr_left - 4'd1;
    assign w_ovf_ext   = r_len_ovf || (r_rem_len[LEN_WIDTH-1 -: 8] != 8'd0);
    assign w_len_shift = {r_rem_len[LEN_WIDTH-9:0], w_b};
    assign w_mask_new  = (r_phase == PH_HDR1) ? w_b[7] : r_mask_on;

    // An extended length starts from zero and is shifted in byte by byte.
    always_comb begin
        unique case (r_phase)
            PH_HDR1:   w_len_new = w_ext ? '0 : {{(LEN_WIDTH-7){1'b0}}, w_len7};
            PH_EXTLEN: w_len_new = w_len_shift;
            default:   w_len_new = r_rem_len;
        endcase
    end

    // The length is complete when a short length arrives or the last
    // extended length byte arrives without overflow.
    assign w_after_len = ((r_phase == PH_HDR1) && !w_ext)
                      || ((r_phase == PH_EXTLEN) && (w_hb_dec == 4'd0) && !w_ovf_ext);
    assign w_start     = (w_after_len && !w_mask_new)
                      || ((r_phase == PH_MASK) && (w_hb_dec == 4'd0));
    assign w_len_empty = (w_len_new == '0);
    assign w_ext_err   = (r_phase == PH_EXTLEN) && (w_hb_dec == 4'd0) && w_ovf_ext;

    always_comb begin
        w_kind_ok = 1'b1;
        w_kind    = KIND_TEXT;
        unique if (r_opcode == OP_TEXT) begin
            w_kind = KIND_TEXT;
        end else if (r_opcode == OP_PING) begin
            w_kind = KIND_PING;
        end else if (r_opcode == OP_CLOSE) begin
            w_kind = KIND_CLOSE;
        end else begin
            w_kind_ok = 1'b0;
        end
    end

    // Payload unmasking; key bytes are used from the most significant down.
    assign w_key_byte = r_mask_key[{~r_mask_pos, 3'b000} +: 8];
    assign w_pay      = r_mask_on ? (w_b ^ w_key_byte) : w_b;
    assign w_rem_dec  = r_rem_len - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
    assign w_pay_last = (w_rem_dec == '0);

    always_comb begin
        w_seen_new  = r_seen;
        w_close_new = r_close_acc;
        if (r_seen == 2'd0) begin
            w_seen_new  = 2'd1;
            w_close_new = {w_pay, 8'h00};
        end else if (r_seen == 2'd1) begin
            w_seen_new  = SEEN_STATUS;
            w_close_new = {r_close_acc[15:8], w_pay};
        end
    end

    // Next parser state.
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_mask_on   = r_mask_on;
        n_hdr_left  = r_hdr_left;
        n_rem_len   = r_rem_len;
        n_len_ovf   = r_len_ovf;
        n_mask_key  = r_mask_key;
        n_mask_pos  = r_mask_pos;
        n_seen      = r_seen;
        n_close_acc = r_close_acc;
        if (w_accept && (s_axis_tuser[0] == CMD_RESTART)) begin
            n_phase     = PH_HDR0;
            n_opcode    = '0;
            n_mask_on   = 1'b0;
            n_hdr_left  = '0;
            n_rem_len   = '0;
            n_len_ovf   = 1'b0;
            n_mask_key  = '0;
            n_mask_pos  = '0;
            n_seen      = '0;
            n_close_acc = '0;
        end else if (w_data) begin
            unique case (r_phase)
                PH_CLOSED: begin
                end
                PH_HDR0: begin
                    n_opcode = w_b[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_mask_on = w_b[7];
                    n_len_ovf = 1'b0;
                    n_rem_len = w_len_new;
                    if (w_ext) begin
                        n_hdr_left = (w_len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        n_phase    = PH_EXTLEN;
                    end
                end
                PH_EXTLEN: begin
                    n_len_ovf  = w_ovf_ext;
                    n_rem_len  = w_len_shift;
                    n_hdr_left = w_hb_dec;
                    if (w_ext_err) begin
                        n_phase = PH_CLOSED;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], w_b};
                    n_hdr_left = w_hb_dec;
                end
                PH_PAYLOAD: begin
                    n_mask_pos  = r_mask_pos + 2'd1;
                    n_seen      = w_seen_new;
                    n_close_acc = w_close_new;
                    n_rem_len   = w_rem_dec;
                    if (w_pay_last) begin
                        n_phase = (r_opcode == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
                    end
                end
                default: begin
                    n_phase = PH_CLOSED;
                end
            endcase

            if (w_after_len && w_mask_new) begin
                n_hdr_left = MASK_BYTES;
                n_mask_key = '0;
                n_phase    = PH_MASK;
            end
            if (w_start) begin
                n_mask_pos  = '0;
                n_seen      = '0;
                n_close_acc = '0;
                if (!w_len_empty) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = (r_opcode == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
                end
            end
        end
    end

    // Result for the accepted request.
    always_comb begin
        n_emit   = 1'b0;
        n_kind   = KIND_TEXT;
        n_byte   = 8'h00;
        n_empty  = 1'b0;
        n_last   = 1'b0;
        n_status = 16'h0000;
        if (w_data) begin
            if (w_ext_err) begin
                n_emit = 1'b1;
                n_kind = KIND_ERROR;
                n_last = 1'b1;
            end else if (w_start && w_len_empty && w_kind_ok) begin
                n_emit  = 1'b1;
                n_kind  = w_kind;
                n_empty = 1'b1;
                n_last  = 1'b1;
            end else if ((r_phase == PH_PAYLOAD) && w_kind_ok) begin
                n_emit = 1'b1;
                n_kind = w_kind;
                n_byte = w_pay;
                n_last = w_pay_last;
                if (w_pay_last && (r_opcode == OP_CLOSE) && (w_seen_new == SEEN_STATUS)) begin
                    n_status = w_close_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CLOSED;
            r_opcode    <= '0;
            r_mask_on   <= 1'b0;
            r_hdr_left  <= '0;
            r_rem_len   <= '0;
            r_len_ovf   <= 1'b0;
            r_mask_key  <= '0;
            r_mask_pos  <= '0;
            r_seen      <= '0;
            r_close_acc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_mask_on   <= n_mask_on;
            r_hdr_left  <= n_hdr_left;
            r_rem_len   <= n_rem_len;
            r_len_ovf   <= n_len_ovf;
            r_mask_key  <= n_mask_key;
            r_mask_pos  <= n_mask_pos;
            r_seen      <= n_seen;
            r_close_acc <= n_close_acc;
            if (w_accept) begin
                r_out_valid <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_empty  <= n_empty;
            r_last   <= n_last;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_status, r_byte};
    assign m_axis_tuser  = {r_empty, r_kind};
    assign m_axis_tlast  = r_last;

    a_restart_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser[0] == CMD_RESTART)) |=> (r_phase == PH_HDR0))
        else $error("restart did not reopen the parser");

    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_data && n_emit && (n_kind == KIND_ERROR)) |=> (r_phase == PH_CLOSED))
        else $error("length error did not close the parser");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_rem_len != '0))
        else $error("payload phase with zero remaining length");

    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MASK) |-> ((r_hdr_left != 4'd0) && (r_hdr_left <= MASK_BYTES)))
        else $error("mask byte count out of range");

endmodule

// File: tb/tb_websocket_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_receiver_core
// Self-checking bench for the WebSocket frame receiver core. Byte requests
// are streamed into s_axis while a parser model in the bench predicts every
// result. A monitor compares each m_axis result field by field against the
// oldest prediction. Directed frames come first, then random traffic under
// several sender gap and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import wsfr_pkg::*;

    localparam int unsigned LEN_W          = 32;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned PHASE_BYTES    = 463;
    localparam int unsigned WHOLE_FRAME    = 32'hFFFF_FFFF;

    typedef enum int unsigned {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        empty;
        logic        last;
        logic [15:0] status;
    } t_rx_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic [0:0]  s_axis_tuser  = '0;   // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] payload_byte, [23:8] close_status
    logic [2:0]  m_axis_tuser;         // [1:0] kind, [2] empty_frame
    logic        m_axis_tlast;         // last

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_sent     = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    logic        link_closed    = 1'b1;
    t_rx_result  pending_results[$];

    // Parser model state.
    t_phase            p_phase    = PH_CLOSED;
    logic [3:0]        p_opcode   = '0;
    logic              p_masked   = 1'b0;
    logic [3:0]        p_hdr_left = '0;
    logic [LEN_W-1:0]  p_len_left = '0;
    logic              p_len_ovf  = 1'b0;
    logic [31:0]       p_key      = '0;
    logic [1:0]        p_key_idx  = '0;
    logic [1:0]        p_seen     = '0;
    logic [15:0]       p_status   = '0;

    websocket_frame_receiver_core #(
        .LEN_WIDTH(LEN_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic logic op_kind(input logic [3:0] op, output logic [1:0] k);
        k = KIND_TEXT;
        if (op == OP_TEXT) begin
            k = KIND_TEXT;
            return 1'b1;
        end
        if (op == OP_PING) begin
            k = KIND_PING;
            return 1'b1;
        end
        if (op == OP_CLOSE) begin
            k = KIND_CLOSE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
                                        input logic e, input logic l,
                                        input logic [15:0] s);
        t_rx_result r;
        r.kind   = k;
        r.data   = d;
        r.empty  = e;
        r.last   = l;
        r.status = s;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void payload_start();
        logic [1:0] k;
        p_key_idx = '0;
        p_seen    = '0;
        p_status  = '0;
        if (p_len_left != 0) begin
            p_phase = PH_PAYLOAD;
        end else begin
            p_phase = (p_opcode == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
            if (op_kind(p_opcode, k))
                push_result(k, 8'h00, 1'b1, 1'b1, 16'h0000);
        end
    endfunction

    function automatic void length_done();
        if (p_masked) begin
            p_hdr_left = MASK_BYTES;
            p_key      = '0;
            p_phase    = PH_MASK;
        end else begin
            payload_start();
        end
    endfunction

    function automatic void model_byte(input logic cmd, input logic [7:0] b);
        logic [1:0]  k;
        logic [7:0]  v;
        logic        lst;
        logic [15:0] st;
        if (cmd == CMD_RESTART) begin
            p_opcode   = '0;
            p_masked   = 1'b0;
            p_hdr_left = '0;
            p_len_left = '0;
            p_len_ovf  = 1'b0;
            p_key      = '0;
            p_key_idx  = '0;
            p_seen     = '0;
            p_status   = '0;
            p_phase    = PH_HDR0;
            return;
        end
        case (p_phase)
            PH_HDR0: begin
                p_opcode = b[3:0];
                p_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                p_masked   = b[7];
                p_len_ovf  = 1'b0;
                p_len_left = '0;
                if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
                    p_hdr_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    p_phase    = PH_EXTLEN;
                end else begin
                    p_len_left = LEN_W'(b[6:0]);
                    length_done();
                end
            end
            PH_EXTLEN: begin
                // Any bit about to be shifted out of the length register means overflow.
                if (p_len_left[LEN_W-1 -: 8] != 0)
                    p_len_ovf = 1'b1;
                p_len_left = {p_len_left[LEN_W-9:0], b};
                p_hdr_left = p_hdr_left - 4'd1;
                if (p_hdr_left == 0) begin
                    if (p_len_ovf) begin
                        p_phase = PH_CLOSED;
                        push_result(KIND_ERROR, 8'h00, 1'b0, 1'b1, 16'h0000);
                    end else begin
                        length_done();
                    end
                end
            end
            PH_MASK: begin
                p_key      = {p_key[23:0], b};
                p_hdr_left = p_hdr_left - 4'd1;
                if (p_hdr_left == 0)
                    payload_start();
            end
            PH_PAYLOAD: begin
                v  = p_masked ? (b ^ p_key[8*(3 - p_key_idx) +: 8]) : b;
                st = 16'h0000;
                p_key_idx = p_key_idx + 2'd1;
                if (p_seen == 0) begin
                    p_status = {v, 8'h00};
                    p_seen   = 2'd1;
                end else if (p_seen == 1) begin
                    p_status[7:0] = v;
                    p_seen        = SEEN_STATUS;
                end
                p_len_left = p_len_left - 1'b1;
                lst = (p_len_left == 0);
                if (lst) begin
                    if (p_opcode == OP_CLOSE) begin
                        if (p_seen >= SEEN_STATUS)
                            st = p_status;
                        p_phase = PH_CLOSED;
                    end else begin
                        p_phase = PH_HDR0;
                    end
                end
                if (op_kind(p_opcode, k))
                    push_result(k, v, 1'b0, lst, st);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on accepted requests, then check accepted results.
    // ------------------------------------------------------------------------
    function automatic void report_mismatch(input string what, input t_rx_result want,
                                            input t_rx_result got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected kind=%0d byte=%02h empty=%0b last=%0b ",
                      "status=%04h, got kind=%0d byte=%02h empty=%0b last=%0b status=%04h"},
                     $realtime, what, want.kind, want.data, want.empty, want.last, want.status,
                     got.kind, got.data, got.empty, got.last, got.status);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rx_result got;
        t_rx_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                model_byte(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind   = m_axis_tuser[1:0];
                got.data   = m_axis_tdata[7:0];
                got.empty  = m_axis_tuser[2];
                got.last   = m_axis_tlast;
                got.status = m_axis_tdata[23:8];
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.empty !== want.empty || got.last !== want.last ||
                        got.status !== want.status)
                        report_mismatch("field mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // A long stretch with no request and no result taken means the block hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** websocket_frame_receiver_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_req(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_RESTART || !link_closed)
            bytes_sent++;
        if (cmd == CMD_RESTART)
            link_closed = 1'b0;
    endtask

    // Builds one frame and sends its first max_bytes bytes.
    task automatic send_ws_frame(input logic [3:0] op, input logic mask_on,
                                 input t_len_form form, input logic [63:0] len,
                                 input int unsigned max_bytes);
        logic [7:0]  frame[$];
        logic [31:0] key;
        logic [6:0]  len7;
        int          n_ext;
        int unsigned n_pay;
        logic        ovf;
        key = $urandom;
        ovf = (form == FORM_EXT64) && ((len >> LEN_W) != 0);
        case (form)
            FORM_SHORT: begin
                len7  = len[6:0];
                n_ext = 0;
            end
            FORM_EXT16: begin
                len7  = LEN7_EXT16;
                n_ext = 2;
            end
            default: begin
                len7  = LEN7_EXT64;
                n_ext = 8;
            end
        endcase
        frame.insert(frame.size(), {4'($urandom), op});
        frame.insert(frame.size(), {mask_on, len7});
        for (int i = n_ext - 1; i >= 0; i--)
            frame.insert(frame.size(), len[8*i +: 8]);
        if (mask_on)
            for (int i = 3; i >= 0; i--)
                frame.insert(frame.size(), key[8*i +: 8]);
        // After a length error the parser is closed, so only a few trailing bytes.
        n_pay = ovf ? $urandom_range(3) : len[31:0];
        // Payload bytes past the cut are never sent, so they are not built.
        if (n_pay > max_bytes)
            n_pay = max_bytes;
        repeat (n_pay)
            frame.insert(frame.size(), 8'($urandom));
        foreach (frame[i])
            if (i < max_bytes)
                send_req(CMD_DATA, frame[i]);
        if (frame.size() <= max_bytes && (ovf || op == OP_CLOSE))
            link_closed = 1'b1;
    endtask

    task automatic random_frame(input int unsigned max_bytes);
        logic [3:0]  op;
        t_len_form   form;
        logic [63:0] len;
        logic [31:0] hi;
        int unsigned r;
        r = $urandom_range(99);
        op = (r < 35) ? OP_TEXT : (r < 55) ? OP_PING : (r < 65) ? OP_CLOSE : 4'($urandom);
        r = $urandom_range(99);
        if (r < 70) begin
            form = FORM_SHORT;
            len  = 64'(($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(125));
        end else if (r < 88) begin
            form = FORM_EXT16;
            len  = 64'((max_bytes != WHOLE_FRAME) ? $urandom_range(16'hFFFF)
                                                  : $urandom_range(130));
        end else begin
            form = FORM_EXT64;
            if ($urandom_range(3) == 0) begin
                hi = 32'($urandom) >> (8 * $urandom_range(3));
                if (hi == 0)
                    hi = 32'd1;
                len = {hi, 32'($urandom)};
            end else if (max_bytes != WHOLE_FRAME) begin
                len = {32'h0, 32'($urandom)};
            end else begin
                len = 64'($urandom_range(40));
            end
        end
        send_ws_frame(op, 1'($urandom), form, len, max_bytes);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_closed_after_reset();
        send_req(CMD_DATA, 8'h00);
        send_req(CMD_DATA, 8'hFF);
        send_req(CMD_RESTART, 8'hA5);
    endtask

    task automatic test_empty_frames();
        send_ws_frame(OP_TEXT, 1'b0, FORM_SHORT, 0, WHOLE_FRAME);
        send_ws_frame(OP_PING, 1'b1, FORM_SHORT, 0, WHOLE_FRAME);
        // A restart in the middle of a header drops the partial frame.
        send_req(CMD_DATA, 8'h81);
        send_req(CMD_RESTART, 8'h00);
        send_ws_frame(OP_CLOSE, 1'b0, FORM_SHORT, 0, WHOLE_FRAME);
        send_req(CMD_RESTART, 8'hFF);
    endtask

    task automatic test_payload_unmasking();
        send_ws_frame(OP_TEXT, 1'b1, FORM_SHORT, 5, WHOLE_FRAME);
        send_ws_frame(OP_PING, 1'b0, FORM_SHORT, 2, WHOLE_FRAME);
        send_ws_frame(4'h2, 1'b1, FORM_SHORT, 3, WHOLE_FRAME);
        send_ws_frame(4'hA, 1'b0, FORM_SHORT, 0, WHOLE_FRAME);
        send_ws_frame(4'h0, 1'b0, FORM_SHORT, 1, WHOLE_FRAME);
    endtask

    task automatic test_extended_lengths();
        send_ws_frame(OP_TEXT, 1'b0, FORM_EXT16, 3, WHOLE_FRAME);
        send_ws_frame(OP_PING, 1'b1, FORM_EXT64, 2, WHOLE_FRAME);
        send_ws_frame(OP_TEXT, 1'b0, FORM_EXT16, 0, WHOLE_FRAME);
    endtask

    task automatic test_close_status();
        send_ws_frame(OP_CLOSE, 1'b1, FORM_SHORT, 1, WHOLE_FRAME);
        send_req(CMD_DATA, 8'h88);
        send_req(CMD_RESTART, 8'h00);
        send_ws_frame(OP_CLOSE, 1'b0, FORM_SHORT, 2, WHOLE_FRAME);
        send_req(CMD_RESTART, 8'h00);
        send_ws_frame(OP_CLOSE, 1'b1, FORM_SHORT, 4, WHOLE_FRAME);
        send_req(CMD_RESTART, 8'h00);
    endtask

    task automatic test_length_overflow();
        send_ws_frame(OP_TEXT, 1'b0, FORM_EXT64, 64'h0000_0001_0000_0000, WHOLE_FRAME);
        send_req(CMD_RESTART, 8'h00);
        send_ws_frame(OP_PING, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, WHOLE_FRAME);
        send_req(CMD_RESTART, 8'h00);
    endtask

    // Mostly well-formed frames, with cut frames, noise and stray restarts.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if (link_closed) begin
                repeat ($urandom_range(2))
                    send_req(CMD_DATA, 8'($urandom));
                send_req(CMD_RESTART, 8'($urandom));
            end
            r = $urandom_range(99);
            if (r < 86) begin
                random_frame(WHOLE_FRAME);
            end else if (r < 93) begin
                random_frame($urandom_range(1, 12));
                send_req(CMD_RESTART, 8'($urandom));
            end else if (r < 97) begin
                repeat ($urandom_range(1, 4))
                    send_req(CMD_DATA, 8'($urandom));
                send_req(CMD_RESTART, 8'($urandom));
            end else begin
                send_req(CMD_RESTART, 8'($urandom));
            end
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_closed_after_reset();
        test_empty_frames();
        test_payload_unmasking();
        test_extended_lengths();
        test_close_status();
        test_length_overflow();
        wait_results_drained();

        bytes_sent = 0;
        test_random_traffic(0, 0, PHASE_BYTES);
        test_random_traffic(71, 0, PHASE_BYTES);
        test_random_traffic(0, 71, PHASE_BYTES);
        test_random_traffic(23, 23, PHASE_BYTES);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** websocket_frame_receiver_core: PASSED **");
        end else begin
            $display("** websocket_frame_receiver_core: FAILED **");
        end
        $finish;
    end

endmodule
